/* design/ccfe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccfe_pkg: shared types and constants of the crc checked frame extractor
// sequencer states, plausible command set, x.25 crc step and result packing
// ----------------------------------------------------------------------------
package ccfe_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h8408;

    localparam int CMD_COUNT = 12;
    localparam logic [7:0] CMD_SET [CMD_COUNT] = '{
        8'h20, 8'h40, 8'h41, 8'h43, 8'h44, 8'h45,
        8'h57, 8'h80, 8'hC7, 8'hC8, 8'hCB, 8'hCC
    };

    // result request layout
    localparam int TDATA_W      = 32;
    localparam int CMD_LSB      = 0;
    localparam int LEN_LSB      = 8;
    localparam int DATA_LSB     = 15;
    localparam int IDX_LSB      = 23;
    localparam int PACK_W       = 29;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CMD_RD,
        ST_CMD_USE,
        ST_LEN_USE,
        ST_CRC_RD,
        ST_CRC_USE,
        ST_FCS_RD,
        ST_FCS_LO,
        ST_FCS_HI,
        ST_PL_RD,
        ST_PL_USE,
        ST_OUT_WAIT,
        ST_COMMIT
    } ccfe_state_t;

    function automatic logic cmd_ok(input logic [7:0] c);
        logic ok;
        ok = 1'b0;
        for (int i = 0; i < CMD_COUNT; i++)
        begin
            if (c == CMD_SET[i])
            begin
                ok = 1'b1;
            end
        end
        return ok;
    endfunction

    // one byte through the reflected x.25 crc
    function automatic logic [15:0] crc_x25_byte(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

/* design/crc_checked_frame_extractor.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc_checked_frame_extractor: byte window deframer with crc-16/x.25 check
//
// s_* takes one received byte per request; m_* gives one request per payload
// byte of each valid frame (cmd, len, payload, crc low byte first), or a
// single request with m_tuser low for an empty payload. cfg_we/cfg_wdata
// set the largest accepted payload length (reset 64); they are to be
// written only while idle, which the block itself does not enforce. Each
// byte is written into a circular window memory, then a small sequencer
// rescans the window from its oldest byte through one shared byte-wide crc
// unit. The window memory has a registered read port, so each window byte
// is read in one state and used in the next. The length of a scan grows
// with rejected headers, headers that wait for more bytes, crc checks over
// len+2 bytes, emitted payload bytes and any time the receiver holds
// m_tready low. s_tready is low during the scan and while a result waits;
// a stalled result holds steady. Reset empties the window and clears
// m_tvalid.
// ----------------------------------------------------------------------------
module crc_checked_frame_extractor
    import ccfe_pkg::*;
#(
    parameter int MAX_PAYLOAD_BYTES = 64
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,    // rx_byte
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,    // frame_cmd, frame_len, data_byte, byte_index
    output logic [0:0]              m_tuser,    // has_data
    output logic                    m_tlast,
    input  wire logic               cfg_we,
    input  wire logic [6:0]         cfg_wdata
);

    localparam int WIN_DEPTH = MAX_PAYLOAD_BYTES + 4;
    localparam int AW        = $clog2(WIN_DEPTH);
    localparam int CW        = $clog2(WIN_DEPTH + 1);
    localparam int SW        = CW + 1;
    localparam int CMP_W     = 10;

    function automatic logic [AW-1:0] win_addr(input logic [AW-1:0] b,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(b) + SW'(off);
        if (s >= SW'(WIN_DEPTH))
        begin
            s = s - SW'(WIN_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    ccfe_state_t        state_reg, state_next;
    logic [AW-1:0]      base_reg, base_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic [6:0]         max_payload_reg, max_payload_next;
    logic               m_tvalid_reg, m_tvalid_next;

    logic [CW-1:0]      rd_off_reg, rd_off_next;
    logic [7:0]         cmd_reg, cmd_next;
    logic [7:0]         len_reg, len_next;
    logic [15:0]        crc_reg, crc_next;
    logic [7:0]         cnt_reg, cnt_next;
    logic [7:0]         fcs_lo_reg, fcs_lo_next;
    logic [6:0]         k_reg, k_next;
    logic [TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic               m_tuser_reg, m_tuser_next;
    logic               m_tlast_reg, m_tlast_next;

    logic [7:0]         win_mem [WIN_DEPTH];
    logic [7:0]         mem_rd_reg;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               wr_en;

    logic [7:0]         limit;
    logic [CW-1:0]      avail;
    logic               hdr_ok;
    logic               frame_fits;
    logic               crc_last;
    logic               fcs_ok;
    logic               k_last;

    // window memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            win_mem[wr_addr] <= s_tdata;
        end
        mem_rd_reg <= win_mem[rd_addr];
    end

    assign wr_en    = s_tvalid && s_tready;
    assign wr_addr  = win_addr(base_reg, count_reg);
    assign rd_addr  = win_addr(base_reg, rd_off_reg);

    assign limit      = (8'(max_payload_reg) > 8'(MAX_PAYLOAD_BYTES)) ?
                        8'(MAX_PAYLOAD_BYTES) : 8'(max_payload_reg);
    assign avail      = count_reg - pos_reg;
    assign hdr_ok     = cmd_ok(cmd_reg) && (mem_rd_reg <= limit);
    assign frame_fits = CMP_W'(avail) >= (CMP_W'(mem_rd_reg) + CMP_W'(4));
    assign crc_last   = (9'(cnt_reg) == (9'(len_reg) + 9'd1));
    assign fcs_ok     = ({mem_rd_reg, fcs_lo_reg} == ~crc_reg);
    assign k_last     = ((8'(k_reg) + 8'd1) == len_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (CMP_W'(avail) < CMP_W'(4))
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    state_next = ST_CMD_RD;
                end
            end
            ST_CMD_RD:   state_next = ST_CMD_USE;
            ST_CMD_USE:  state_next = ST_LEN_USE;
            ST_LEN_USE:
            begin
                priority if (!hdr_ok)
                begin
                    state_next = ST_CHECK;
                end
                else if (!frame_fits)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    state_next = ST_CRC_RD;
                end
            end
            ST_CRC_RD:   state_next = ST_CRC_USE;
            ST_CRC_USE:  state_next = crc_last ? ST_FCS_RD : ST_CRC_RD;
            ST_FCS_RD:   state_next = ST_FCS_LO;
            ST_FCS_LO:   state_next = ST_FCS_HI;
            ST_FCS_HI:
            begin
                priority if (!fcs_ok)
                begin
                    state_next = ST_CHECK;
                end
                else if (len_reg == 8'd0)
                begin
                    state_next = ST_OUT_WAIT;
                end
                else
                begin
                    state_next = ST_PL_RD;
                end
            end
            ST_PL_RD:    state_next = ST_PL_USE;
            ST_PL_USE:   state_next = ST_OUT_WAIT;
            ST_OUT_WAIT:
            begin
                if (m_tready)
                begin
                    state_next = m_tlast_reg ? ST_COMMIT : ST_PL_RD;
                end
            end
            ST_COMMIT:   state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        base_next        = base_reg;
        count_next       = count_reg;
        pos_next         = pos_reg;
        max_payload_next = max_payload_reg;
        m_tvalid_next    = m_tvalid_reg;
        rd_off_next      = rd_off_reg;
        cmd_next         = cmd_reg;
        len_next         = len_reg;
        crc_next         = crc_reg;
        cnt_next         = cnt_reg;
        fcs_lo_next      = fcs_lo_reg;
        k_next           = k_reg;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        m_tlast_next     = m_tlast_reg;

        if (cfg_we)
        begin
            max_payload_next = cfg_wdata;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                pos_next = '0;
                if (s_tvalid)
                begin
                    // a full window drops its oldest byte
                    if (count_reg == CW'(WIN_DEPTH))
                    begin
                        base_next = win_addr(base_reg, CW'(1));
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            ST_CHECK:
            begin
                rd_off_next = pos_reg;
            end
            ST_CMD_RD:
            begin
                rd_off_next = pos_reg + CW'(1);
            end
            ST_CMD_USE:
            begin
                cmd_next = mem_rd_reg;
            end
            ST_LEN_USE:
            begin
                len_next    = mem_rd_reg;
                crc_next    = CRC_INIT;
                cnt_next    = '0;
                rd_off_next = pos_reg;
                if (!hdr_ok)
                begin
                    pos_next = pos_reg + CW'(1);
                end
            end
            ST_CRC_RD:
            begin
            end
            ST_CRC_USE:
            begin
                crc_next    = crc_x25_byte(crc_reg, mem_rd_reg);
                cnt_next    = cnt_reg + 8'd1;
                rd_off_next = rd_off_reg + CW'(1);
            end
            ST_FCS_RD:
            begin
                rd_off_next = rd_off_reg + CW'(1);
            end
            ST_FCS_LO:
            begin
                fcs_lo_next = mem_rd_reg;
            end
            ST_FCS_HI:
            begin
                k_next      = '0;
                rd_off_next = pos_reg + CW'(2);
                priority if (!fcs_ok)
                begin
                    pos_next = pos_reg + CW'(1);
                end
                else if (len_reg == 8'd0)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = TDATA_W'(cmd_reg) << CMD_LSB;
                    m_tuser_next  = 1'b0;
                    m_tlast_next  = 1'b1;
                end
                else
                begin
                end
            end
            ST_PL_RD:
            begin
            end
            ST_PL_USE:
            begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = TDATA_W'({k_reg[5:0], mem_rd_reg, len_reg[6:0], cmd_reg});
                m_tuser_next  = 1'b1;
                m_tlast_next  = k_last;
            end
            ST_OUT_WAIT:
            begin
                if (m_tready)
                begin
                    m_tvalid_next = 1'b0;
                    if (m_tlast_reg)
                    begin
                        pos_next = pos_reg + CW'(len_reg) + CW'(4);
                    end
                    else
                    begin
                        k_next      = k_reg + 7'd1;
                        rd_off_next = rd_off_reg + CW'(1);
                    end
                end
            end
            ST_COMMIT:
            begin
                base_next  = win_addr(base_reg, pos_reg);
                count_next = count_reg - pos_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            base_reg        <= '0;
            count_reg       <= '0;
            pos_reg         <= '0;
            max_payload_reg <= 7'd64;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            base_reg        <= base_next;
            count_reg       <= count_next;
            pos_reg         <= pos_next;
            max_payload_reg <= max_payload_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_off_reg  <= rd_off_next;
        cmd_reg     <= cmd_next;
        len_reg     <= len_next;
        crc_reg     <= crc_next;
        cnt_reg     <= cnt_next;
        fcs_lo_reg  <= fcs_lo_next;
        k_reg       <= k_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

endmodule
`default_nettype wire

/* design/ccfe_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccfe_checker: port level checks of the crc checked frame extractor
// result request shape and input/output exclusion, bound to the top level
// ----------------------------------------------------------------------------
module ccfe_checker
    import ccfe_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               s_tready,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata,
    input wire logic [0:0]         m_tuser,
    input wire logic               m_tlast
);

    // stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result request dropped while stalled");

    // no new byte taken while a result waits
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // empty frame gives one final request
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("empty frame result not last");

    // empty frame carries zero length, data and index
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> (m_tdata[PACK_W-1:LEN_LSB] == '0))
        else $error("empty frame result not cleared");

    // payload request has a nonzero length
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata[DATA_LSB-1:LEN_LSB] != '0))
        else $error("payload result with zero length");

endmodule

bind crc_checked_frame_extractor ccfe_checker u_ccfe_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
